### sv/assert_macros.svh
// Assertion macros shared by the cycles_to_time_units RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check an implication in the following cycle, outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/ctu_pkg.sv
// Package for cycles_to_time_units: unit codes, widths and the rate table.
// No dependencies.
`timescale 1ns / 1ps
package ctu_pkg;
	localparam int unsigned HZ_W = 32;
	localparam int unsigned CNT_W = 64;
	localparam int unsigned UPS_W = 20;
	localparam logic [UPS_W-1:0] US_PER_SEC = 20'd1000000;
	localparam logic [UPS_W-1:0] MS_PER_SEC = 20'd1000;

	typedef enum logic {
		UNIT_US = 1'b0,
		UNIT_MS = 1'b1
	} unit_t;

	// Units per second for the selected unit.
	function automatic logic [UPS_W-1:0] units_per_sec(input unit_t u);
		logic [UPS_W-1:0] r;
		case (u)
			UNIT_US: r = US_PER_SEC;
			UNIT_MS: r = MS_PER_SEC;
			default: r = US_PER_SEC;
		endcase
		return r;
	endfunction
endpackage

### sv/ctu_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Uses ctu_pkg widths; side data travels with each item.
`timescale 1ns / 1ps
module ctu_div import ctu_pkg::*; #(
	parameter int unsigned QW = 64,
	parameter int unsigned SW = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [HZ_W-1:0] in_rem,
	input  logic [QW-1:0]   in_num,
	input  logic [SW-1:0]   in_side,
	input  logic [HZ_W-1:0] divisor,
	output logic            out_valid,
	output logic [QW-1:0]   out_quot,
	output logic [HZ_W-1:0] out_rem,
	output logic [SW-1:0]   out_side
);
	logic            vld_s  [0:QW];
	logic [HZ_W-1:0] rem_s  [0:QW];
	logic [QW-1:0]   num_s  [0:QW];
	logic [SW-1:0]   side_s [0:QW];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = in_rem;
	assign num_s[0]  = in_num;
	assign side_s[0] = in_side;

	genvar i;
	generate
		for (i = 0; i < QW; i++) begin : g_stage
			logic [HZ_W:0] trial;
			logic          ge;
			logic [HZ_W:0] diff;
			assign trial = {rem_s[i], num_s[i][QW-1]};
			assign ge    = trial >= {1'b0, divisor};
			assign diff  = trial - {1'b0, divisor};

			// Advance valid with the whole pipe.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i+1] <= 1'b0;
				end else if (en) begin
					vld_s[i+1] <= vld_s[i];
				end
			end

			// Shift in one quotient bit, keep the partial remainder.
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i+1]  <= ge ? diff[HZ_W-1:0] : trial[HZ_W-1:0];
					num_s[i+1]  <= {num_s[i][QW-2:0], ge};
					side_s[i+1] <= side_s[i];
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[QW];
	assign out_quot  = num_s[QW];
	assign out_rem   = rem_s[QW];
	assign out_side  = side_s[QW];
endmodule

### sv/cycles_to_time_units.sv
// cycles_to_time_units: converts a 64-bit cycle count to microseconds or
// milliseconds at a configured clock rate.
//
// Input stream s_axis: tdata carries the cycle count, tuser the unit select
// (0 microseconds, 1 milliseconds). Output stream m_axis: tdata carries the
// elapsed time; a millisecond result keeps only its low 32 bits.
// Config channel cfg: write clock_hz (hertz); write it only while idle, as
// the block does not enforce this. A zero clock rate yields a zero result.
// Stages: 64 for count / clock_hz (one quotient bit per stage), one
// multiply stage, one sum stage, 20 stages for leftover * units / clock_hz
// and the output register.
// One transaction is taken every cycle while no result waits or m_axis_tready is high.
// The whole pipe advances as one; when m_axis_tready is low and a result is
// waiting, the pipe holds and s_axis_tready drops, so nothing is lost.
// Reset clears all valid bits and sets clock_hz to 1 MHz.
// Depends on ctu_pkg, ctu_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cycles_to_time_units import ctu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [CNT_W-1:0]  s_axis_tdata,   // [63:0] cycles
	input  logic              s_axis_tuser,   // [0] func
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [CNT_W-1:0]  m_axis_tdata,   // [63:0] time_units
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [HZ_W-1:0]   cfg_data
);
	typedef struct packed {
		logic  zero;
		unit_t unit;
	} tag_t;

	typedef struct packed {
		tag_t             tag;
		logic [CNT_W-1:0] base;
	} side2_t;

	localparam int unsigned PR_W = HZ_W + UPS_W;

	logic [HZ_W-1:0] clock_hz_q;
	logic            en;
	logic            out_valid_q;
	logic [CNT_W-1:0] out_data_q;

	// Hold the clock rate register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q <= 32'd1000000;
		end else if (cfg_valid) begin
			clock_hz_q <= cfg_data;
		end
	end

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// Whole seconds and leftover cycles.
	tag_t             tag_in;
	logic             d1_valid;
	logic [CNT_W-1:0] d1_quot;
	logic [HZ_W-1:0]  d1_rem;
	tag_t             d1_tag;

	assign tag_in.zero = (clock_hz_q == '0);
	assign tag_in.unit = unit_t'(s_axis_tuser);

	ctu_div #(.QW(CNT_W), .SW($bits(tag_t))) u_div_sec (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(s_axis_tvalid), .in_rem('0), .in_num(s_axis_tdata),
		.in_side(tag_in), .divisor(clock_hz_q),
		.out_valid(d1_valid), .out_quot(d1_quot), .out_rem(d1_rem), .out_side(d1_tag)
	);

	// Multiply stage: partial products of seconds and leftover by the rate.
	logic [UPS_W-1:0] ups;
	logic             m1_valid_s1;
	tag_t             m1_tag_s1;
	logic [PR_W-1:0]  plo_s1, phi_s1, prest_s1;
	assign ups = units_per_sec(d1_tag.unit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_valid_s1 <= 1'b0;
		end else if (en) begin
			m1_valid_s1 <= d1_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m1_tag_s1 <= d1_tag;
			plo_s1    <= d1_quot[HZ_W-1:0] * ups;
			phi_s1    <= d1_quot[CNT_W-1:HZ_W] * ups;
			prest_s1  <= d1_rem * ups;
		end
	end

	// Sum stage: seconds term modulo 2^64.
	logic             m2_valid_s2;
	side2_t           m2_side_s2;
	logic [PR_W-1:0]  prest_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m2_valid_s2 <= 1'b0;
		end else if (en) begin
			m2_valid_s2 <= m1_valid_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m2_side_s2.tag  <= m1_tag_s1;
			m2_side_s2.base <= {{(CNT_W-PR_W){1'b0}}, plo_s1}
				+ {phi_s1[HZ_W-1:0], {HZ_W{1'b0}}};
			prest_s2        <= prest_s1;
		end
	end

	// Fraction: leftover product / clock rate, quotient below 2^20.
	logic             d2_valid;
	logic [UPS_W-1:0] d2_quot;
	logic [HZ_W-1:0]  d2_rem;
	side2_t           d2_side;
	ctu_div #(.QW(UPS_W), .SW($bits(side2_t))) u_div_frac (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(m2_valid_s2), .in_rem(prest_s2[PR_W-1:UPS_W]),
		.in_num(prest_s2[UPS_W-1:0]), .in_side(m2_side_s2), .divisor(clock_hz_q),
		.out_valid(d2_valid), .out_quot(d2_quot), .out_rem(d2_rem), .out_side(d2_side)
	);

	// Output register: add, wrap milliseconds, zero for a zero rate.
	logic [CNT_W-1:0] total;
	assign total = d2_side.base + {{(CNT_W-UPS_W){1'b0}}, d2_quot};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d2_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (d2_side.tag.zero) begin
				out_data_q <= '0;
			end else if (d2_side.tag.unit == UNIT_MS) begin
				out_data_q <= {{(CNT_W-HZ_W){1'b0}}, total[HZ_W-1:0]};
			end else begin
				out_data_q <= total;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	`ASSERT_IMP(a_frac_range, clk, arst_n, d2_valid && !d2_side.tag.zero,
		(d2_quot < units_per_sec(d2_side.tag.unit)) && (d2_rem < clock_hz_q))
	`ASSERT_NEXT(a_ms_high_zero, clk, arst_n, en && d2_valid && d2_side.tag.unit == UNIT_MS,
		m_axis_tdata[CNT_W-1:HZ_W] == '0)
	`ASSERT_NEXT(a_zero_rate, clk, arst_n, en && d2_valid && d2_side.tag.zero,
		m_axis_tdata == '0)
endmodule

### bench/tb.sv
// Self-checking bench for cycles_to_time_units: directed rows, then random traffic.
// Depends on ctu_pkg and the cycles_to_time_units RTL only.
`timescale 1ns / 1ps
module tb;
	import ctu_pkg::*;

	localparam int unsigned LATENCY = 87;
	localparam int unsigned N_RANDOM = 700;
	localparam longint unsigned CYCLE_LIMIT = 400000;

	typedef struct {
		logic [CNT_W-1:0] cycles;
		unit_t            unit;
		logic             known;   // expected value typed in below
		logic [CNT_W-1:0] value;
	} conv_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [CNT_W-1:0] s_axis_tdata;
	logic             s_axis_tuser;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [CNT_W-1:0] m_axis_tdata;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [HZ_W-1:0]  cfg_data;

	logic [HZ_W-1:0]  clock_rate;
	logic [CNT_W-1:0] pending_times[$];
	int unsigned      src_idle_pct;
	int unsigned      snk_idle_pct;
	longint unsigned  cycle_count;
	bit               failed;
	conv_row_t        rows[$];

	cycles_to_time_units u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Split count into whole seconds and leftover cycles, then scale each part.
	function automatic logic [CNT_W-1:0] elapsed_time(logic [CNT_W-1:0] cycles, unit_t unit,
			logic [HZ_W-1:0] hz);
		logic [CNT_W-1:0] rate;
		logic [CNT_W-1:0] per_sec;
		logic [CNT_W-1:0] sum;
		rate = {32'd0, hz};
		per_sec = (unit == UNIT_MS) ? 64'd1000 : 64'd1000000;
		if (hz == '0)
			return '0;
		sum = (cycles / rate) * per_sec + ((cycles % rate) * per_sec) / rate;
		if (unit == UNIT_MS)
			sum[63:32] = '0;
		return sum;
	endfunction

	// Give up after a generous number of cycles.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("cycles_to_time_units regression: fail");
			$finish;
		end
	end

	// Check each result transaction against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_times.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, m_axis_tdata);
				failed = 1'b1;
			end else begin
				if (m_axis_tdata !== pending_times[0]) begin
					$display("%0t: time_units expected %h actual %h", $realtime,
						pending_times[0], m_axis_tdata);
					failed = 1'b1;
				end
				void'(pending_times.pop_front());
			end
		end
	end

	// Stall the receiver at random on each falling edge.
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Offer one input transaction and queue its expected time.
	task automatic send_count(logic [CNT_W-1:0] cycles, unit_t unit, logic known,
			logic [CNT_W-1:0] value);
		logic [CNT_W-1:0] pred;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		pred = elapsed_time(cycles, unit, clock_rate);
		if (known && pred !== value) begin
			$display("%0t: table row expected %h, predictor %h", $realtime, value, pred);
			failed = 1'b1;
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= cycles;
		s_axis_tuser <= unit;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_times.push_back(known ? value : pred);
		@(negedge clk);
	endtask

	// Wait until everything is out, then let the pipe drain.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_times.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	// Write clock_hz while the block is idle.
	task automatic set_clock(logic [HZ_W-1:0] hz);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= hz;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		clock_rate = hz;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Modest counts about half the time, otherwise full 64-bit ones.
	function automatic logic [CNT_W-1:0] random_count();
		logic [CNT_W-1:0] c;
		c = {$urandom, $urandom};
		case ($urandom_range(3))
			0: c = c >> $urandom_range(63);
			1: c = c % ({32'd0, clock_rate} + 1);
			default: ;
		endcase
		return c;
	endfunction

	// Pick a clock rate, extremes included.
	function automatic logic [HZ_W-1:0] random_rate();
		case ($urandom_range(5))
			0: return 32'd1000000;
			1: return 32'hFFFF_FFFF;
			2: return '0;
			3: return $urandom_range(999999, 1);
			default: return $urandom_range(32'hFFFF_FFFF, 1000000);
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		clock_rate = 32'd1000000;
		cycle_count = 0;
		failed = 1'b0;
		src_idle_pct = 18;
		snk_idle_pct = 58;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table at reset rate (1 MHz): microseconds equal cycles.
		rows.push_back('{64'd0, UNIT_US, 1'b1, 64'd0});
		rows.push_back('{64'd0, UNIT_MS, 1'b1, 64'd0});
		rows.push_back('{64'd999, UNIT_MS, 1'b1, 64'd0});
		rows.push_back('{64'd1000, UNIT_MS, 1'b1, 64'd1});
		rows.push_back('{64'd123456789, UNIT_US, 1'b1, 64'd123456789});
		rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, UNIT_US, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF});
		rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, UNIT_MS, 1'b0, 64'd0});
		rows.push_back('{64'h8000_0000_0000_0000, UNIT_MS, 1'b0, 64'd0});
		rows.push_back('{64'd999999, UNIT_US, 1'b1, 64'd999999});
		foreach (rows[i])
			send_count(rows[i].cycles, rows[i].unit, rows[i].known, rows[i].value);

		// Zero clock rate gives zero.
		set_clock('0);
		send_count(64'hFFFF_FFFF_FFFF_FFFF, UNIT_US, 1'b1, 64'd0);
		send_count(64'd5, UNIT_MS, 1'b1, 64'd0);
		// Top rate, sub-megahertz rates (seconds term wraps).
		set_clock(32'hFFFF_FFFF);
		send_count(64'hFFFF_FFFF, UNIT_US, 1'b1, 64'd1000000);
		send_count(64'hFFFF_FFFF_FFFF_FFFF, UNIT_US, 1'b0, 64'd0);
		send_count(64'hFFFF_FFFE, UNIT_MS, 1'b0, 64'd0);
		set_clock(32'd1);
		send_count(64'hFFFF_FFFF_FFFF_FFFF, UNIT_US, 1'b0, 64'd0);
		send_count(64'd7, UNIT_MS, 1'b1, 64'd7000);
		set_clock(32'd999999);
		send_count(64'hFFFF_FFFF_FFFF_FFFF, UNIT_MS, 1'b0, 64'd0);

		// Random phases: idle pattern switches, rate changes between blocks.
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 58 : 0;
			snk_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 18 : 0;
			for (int blk = 0; blk < 4; blk++) begin
				set_clock(random_rate());
				for (int n = 0; n < N_RANDOM / 12; n++)
					send_count(random_count(), unit_t'($urandom_range(1)), 1'b0, '0);
			end
		end

		drain();
		if (!failed)
			$display("cycles_to_time_units regression: pass");
		else
			$display("cycles_to_time_units regression: fail");
		$finish;
	end
endmodule
